FILE: rtl/core/mtvs_pkg.sv
// ----------------------------------------------------------------------------
// mtvs_pkg
// Shared constants for the mouse to virtual stick block: request kinds,
// configuration register indexes, reset values and fixed-point scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package mtvs_pkg;

    // Request kinds carried on the mode field.
    localparam logic [1:0] MODE_FRAME   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE  = 2'd1;
    localparam logic [1:0] MODE_DISCARD = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 20;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SENS_STEP   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERT_Y    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAP_WINDOW  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_GAP     = 3'd4;

    // Register reset values.
    localparam logic [3:0]  SENS_STEP_RESET  = 4'd4;
    localparam logic [19:0] TAP_WINDOW_RESET = 20'd250000;
    localparam logic [19:0] MAX_GAP_RESET    = 20'd100000;

    // Highest usable sensitivity step; larger values saturate to it.
    localparam logic [3:0] SENS_STEP_MAX = 4'd8;

    // Gain is 127/256 * 2^(step-4): a multiply by the full-scale value and a
    // shift by FRAC_BITS + step - SCALE_BIAS.
    localparam int SCALE_BIAS       = 12;
    localparam int STICK_FULL_SCALE = 127;

    // Default parameter values.
    localparam int FRAC_BITS_DEFAULT     = 12;
    localparam int PENDING_WIDTH_DEFAULT = 24;

endpackage

`default_nettype wire

FILE: rtl/core/mtvs_axis_step.sv
// ----------------------------------------------------------------------------
// mtvs_axis_step
// One stick axis update: scales a pending pixel sum by the sensitivity gain,
// optionally negates it and adds it to the stick with clamping to full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module mtvs_axis_step
    import mtvs_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEFAULT,
    parameter int PENDING_WIDTH = PENDING_WIDTH_DEFAULT
)
(
    input  wire logic [3:0]                      step,
    input  wire logic                            negate,
    input  wire logic signed [PENDING_WIDTH-1:0] pending,
    input  wire logic signed [FRAC_BITS+7:0]     stick,
    output logic signed [FRAC_BITS+7:0]          stick_new
);

    localparam int SW = FRAC_BITS + 8;
    localparam int WW = PENDING_WIDTH + FRAC_BITS + 8;
    localparam logic signed [WW-1:0] STICK_MAX =
        WW'(longint'(STICK_FULL_SCALE) <<< FRAC_BITS);
    localparam logic signed [WW-1:0] STICK_MIN = -STICK_MAX;

    logic [3:0]              step_sat;
    logic [5:0]              exp_sum;
    logic [4:0]              lsh;
    logic [4:0]              rsh;
    logic signed [WW-1:0]    p_ext;
    logic signed [WW-1:0]    scaled;
    logic signed [WW-1:0]    shifted;
    logic signed [WW-1:0]    delta;
    logic signed [WW-1:0]    sum;

    always_comb
    begin
        step_sat = (step > SENS_STEP_MAX) ? SENS_STEP_MAX : step;
        exp_sum  = 6'(FRAC_BITS) + {2'b00, step_sat};
        lsh      = (exp_sum >= 6'(SCALE_BIAS)) ? 5'(exp_sum - 6'(SCALE_BIAS)) : 5'd0;
        rsh      = (exp_sum <  6'(SCALE_BIAS)) ? 5'(6'(SCALE_BIAS) - exp_sum) : 5'd0;

        // The constant multiply reduces to a shift and a subtract.
        p_ext    = WW'(pending);
        scaled   = p_ext * WW'(STICK_FULL_SCALE);

        // At most one of the two shifts is non-zero; the right shift floors.
        shifted  = (scaled <<< lsh) >>> rsh;
        delta    = negate ? -shifted : shifted;
        sum      = WW'(stick) + delta;

        if (sum > STICK_MAX)
        begin
            stick_new = SW'(STICK_MAX);
        end
        else if (sum < STICK_MIN)
        begin
            stick_new = SW'(STICK_MIN);
        end
        else
        begin
            stick_new = SW'(sum);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mouse_to_virtual_stick.sv
// ----------------------------------------------------------------------------
// mouse_to_virtual_stick
// Turns relative mouse motion into a held virtual joystick with roll lock,
// tap detection and one-shot button actions.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Contents
//  input     in         in_valid / in_ready   mode, buttons, motion, now_us
//  output    out        out_valid / out_ready flags, axes, lock and fire state
//  config    in         cfg_we (no wait)      cfg_index, cfg_data
//
// A request waits in the input register until the result register is free or
// is being emptied; the edge that moves it on updates the state and loads the
// result flags, which are then offered until they are taken. A new
// request is accepted every cycle while results are taken; the single state
// update per request, fed from the input register, sets that rate.
// Reset clears all state and loads the configuration reset values.
// A stalled output holds the state at the result shown, and the input
// register keeps one request waiting behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_to_virtual_stick
    import mtvs_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEFAULT,
    parameter int PENDING_WIDTH = PENDING_WIDTH_DEFAULT
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // Configuration write port.
    input  wire logic                        cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]   cfg_data,

    // Input request channel.
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  mode,
    input  wire logic                        allowed,
    input  wire logic                        captured,
    input  wire logic                        chat_inactive,
    input  wire logic signed [15:0]          rel_x,
    input  wire logic signed [15:0]          rel_y,
    input  wire logic                        left_held,
    input  wire logic                        right_held,
    input  wire logic                        middle_pressed,
    input  wire logic                        x1_pressed,
    input  wire logic [31:0]                 now_us,

    // Result channel.
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             sample_valid,
    output logic signed [7:0]                axis_x,
    output logic signed [7:0]                axis_y,
    output logic signed [7:0]                axis_r,
    output logic                             fire_button,
    output logic                             roll_locked,
    output logic                             tap_action,
    output logic                             nearest_action,
    output logic                             view_action,
    output logic                             engaged
);

    localparam int SW = FRAC_BITS + 8;
    localparam int PW = PENDING_WIDTH;
    localparam logic signed [PW-1:0] PEND_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PEND_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [SW:0]   HALF_LSB = (SW+1)'(1) <<< (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic        enable_reg;
    logic [3:0]  sens_step_reg;
    logic        invert_y_reg;
    logic [19:0] tap_window_reg;
    logic [19:0] max_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            sens_step_reg  <= SENS_STEP_RESET;
            invert_y_reg   <= 1'b0;
            tap_window_reg <= TAP_WINDOW_RESET;
            max_gap_reg    <= MAX_GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_SENS_STEP:  sens_step_reg  <= cfg_data[3:0];
                REG_INVERT_Y:   invert_y_reg   <= cfg_data[0];
                REG_TAP_WINDOW: tap_window_reg <= cfg_data;
                REG_MAX_GAP:    max_gap_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. A request moves on when the result register is
    // empty or its contents are taken in the same cycle.
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic [1:0]         mode_reg;
    logic               allowed_reg;
    logic               captured_reg;
    logic               chat_ok_reg;
    logic signed [15:0] rel_x_reg;
    logic signed [15:0] rel_y_reg;
    logic               left_reg;
    logic               right_reg;
    logic               middle_reg;
    logic               x1_reg;
    logic [31:0]        now_reg;

    logic               out_valid_reg;
    logic               advance;
    logic               in_accept;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg     <= mode;
            allowed_reg  <= allowed;
            captured_reg <= captured;
            chat_ok_reg  <= chat_inactive;
            rel_x_reg    <= rel_x;
            rel_y_reg    <= rel_y;
            left_reg     <= left_held;
            right_reg    <= right_held;
            middle_reg   <= middle_pressed;
            x1_reg       <= x1_pressed;
            now_reg      <= now_us;
        end
    end

    // ------------------------------------------------------------------
    // Block state. It only changes when a request moves into the result
    // register, so between updates it always matches the result shown.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] pending_x_reg, pending_x_next;
    logic signed [PW-1:0] pending_y_reg, pending_y_next;
    logic signed [SW-1:0] stick_x_reg, stick_x_next;
    logic signed [SW-1:0] stick_y_reg, stick_y_next;
    logic signed [SW-1:0] stick_r_reg, stick_r_next;
    logic                 lock_roll_reg, lock_roll_next;
    logic                 lock_drained_reg, lock_drained_next;
    logic                 right_down_reg, right_down_next;
    logic [31:0]          press_time_reg, press_time_next;
    logic [31:0]          drain_time_reg, drain_time_next;
    logic                 drain_seen_reg, drain_seen_next;
    logic                 active_reg, active_next;
    logic                 left_state_reg, left_state_next;

    logic sample_valid_reg, sample_valid_next;
    logic tap_reg, tap_next;
    logic near_reg, near_next;
    logic view_reg, view_next;

    // Stick updates for the three axes. Roll restarts from zero when the
    // lock has changed since the last sample that was not stale.
    logic signed [SW-1:0] stick_r_base;
    logic signed [SW-1:0] new_x, new_y, new_r;

    assign stick_r_base = (lock_roll_reg != lock_drained_reg) ? '0 : stick_r_reg;

    mtvs_axis_step #(
        .FRAC_BITS     (FRAC_BITS),
        .PENDING_WIDTH (PENDING_WIDTH)
    ) u_step_x (
        .step      (sens_step_reg),
        .negate    (1'b0),
        .pending   (pending_x_reg),
        .stick     (stick_x_reg),
        .stick_new (new_x)
    );

    // Mouse Y grows downward, so pitch is negated unless inversion is set.
    mtvs_axis_step #(
        .FRAC_BITS     (FRAC_BITS),
        .PENDING_WIDTH (PENDING_WIDTH)
    ) u_step_y (
        .step      (sens_step_reg),
        .negate    (!invert_y_reg),
        .pending   (pending_y_reg),
        .stick     (stick_y_reg),
        .stick_new (new_y)
    );

    // Under roll lock, horizontal motion drives roll instead of yaw.
    mtvs_axis_step #(
        .FRAC_BITS     (FRAC_BITS),
        .PENDING_WIDTH (PENDING_WIDTH)
    ) u_step_r (
        .step      (sens_step_reg),
        .negate    (1'b0),
        .pending   (pending_x_reg),
        .stick     (stick_r_base),
        .stick_new (new_r)
    );

    // Saturating pending sums.
    logic signed [PW:0]   sum_x, sum_y;
    logic signed [PW-1:0] pend_x_sat, pend_y_sat;

    always_comb
    begin
        sum_x = (PW+1)'(pending_x_reg) + (PW+1)'(rel_x_reg);
        sum_y = (PW+1)'(pending_y_reg) + (PW+1)'(rel_y_reg);
        if (sum_x[PW] != sum_x[PW-1])
        begin
            pend_x_sat = sum_x[PW] ? PEND_MIN : PEND_MAX;
        end
        else
        begin
            pend_x_sat = PW'(sum_x);
        end
        if (sum_y[PW] != sum_y[PW-1])
        begin
            pend_y_sat = sum_y[PW] ? PEND_MIN : PEND_MAX;
        end
        else
        begin
            pend_y_sat = PW'(sum_y);
        end
    end

    // Time since the right press (taken from the fresh press on a new
    // press) and since the last drain, both modulo 2^32.
    logic        new_press;
    logic [31:0] held_for;
    logic [31:0] since_press;
    logic [31:0] gap;
    logic        stale;
    logic        do_clear;

    assign new_press   = right_reg && !right_down_reg;
    assign since_press = now_reg - press_time_reg;
    assign held_for    = new_press ? 32'd0 : since_press;
    assign gap         = now_reg - drain_time_reg;
    assign stale       = !drain_seen_reg || (gap > 32'(max_gap_reg));

    always_comb
    begin
        pending_x_next    = pending_x_reg;
        pending_y_next    = pending_y_reg;
        stick_x_next      = stick_x_reg;
        stick_y_next      = stick_y_reg;
        stick_r_next      = stick_r_reg;
        lock_roll_next    = lock_roll_reg;
        lock_drained_next = lock_drained_reg;
        right_down_next   = right_down_reg;
        press_time_next   = press_time_reg;
        drain_time_next   = drain_time_reg;
        drain_seen_next   = drain_seen_reg;
        active_next       = active_reg;
        left_state_next   = left_state_reg;
        sample_valid_next = 1'b0;
        tap_next          = 1'b0;
        near_next         = 1'b0;
        view_next         = 1'b0;
        do_clear          = 1'b0;

        case (mode_reg)
            MODE_FRAME:
            begin
                if (!enable_reg || !(allowed_reg && captured_reg))
                begin
                    do_clear = 1'b1;
                end
                else
                begin
                    active_next     = 1'b1;
                    pending_x_next  = pend_x_sat;
                    pending_y_next  = pend_y_sat;
                    left_state_next = left_reg;
                    if (new_press)
                    begin
                        press_time_next = now_reg;
                    end
                    right_down_next = right_reg;
                    lock_roll_next  = right_reg && (held_for >= 32'(tap_window_reg));
                    if (chat_ok_reg)
                    begin
                        // A release inside the window is a tap.
                        tap_next  = !right_reg && right_down_reg &&
                                    (since_press < 32'(tap_window_reg));
                        near_next = middle_reg;
                        view_next = x1_reg;
                    end
                end
            end
            MODE_SAMPLE:
            begin
                if (!allowed_reg || !enable_reg)
                begin
                    do_clear = 1'b1;
                end
                else if (active_reg)
                begin
                    drain_time_next   = now_reg;
                    drain_seen_next   = 1'b1;
                    pending_x_next    = '0;
                    pending_y_next    = '0;
                    sample_valid_next = 1'b1;
                    // A stale interval drops the motion and keeps the sticks.
                    if (!stale)
                    begin
                        lock_drained_next = lock_roll_reg;
                        if (lock_roll_reg)
                        begin
                            stick_r_next = new_r;
                        end
                        else
                        begin
                            stick_r_next = '0;
                            stick_x_next = new_x;
                            stick_y_next = new_y;
                        end
                    end
                end
            end
            MODE_DISCARD:
            begin
                pending_x_next  = '0;
                pending_y_next  = '0;
                drain_time_next = now_reg;
                drain_seen_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Internal reset leaves the press time alone.
        if (do_clear)
        begin
            pending_x_next    = '0;
            pending_y_next    = '0;
            stick_x_next      = '0;
            stick_y_next      = '0;
            stick_r_next      = '0;
            lock_roll_next    = 1'b0;
            lock_drained_next = 1'b0;
            right_down_next   = 1'b0;
            drain_time_next   = '0;
            drain_seen_next   = 1'b0;
            active_next       = 1'b0;
            left_state_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_x_reg    <= '0;
            pending_y_reg    <= '0;
            stick_x_reg      <= '0;
            stick_y_reg      <= '0;
            stick_r_reg      <= '0;
            lock_roll_reg    <= 1'b0;
            lock_drained_reg <= 1'b0;
            right_down_reg   <= 1'b0;
            press_time_reg   <= '0;
            drain_time_reg   <= '0;
            drain_seen_reg   <= 1'b0;
            active_reg       <= 1'b0;
            left_state_reg   <= 1'b0;
            sample_valid_reg <= 1'b0;
            tap_reg          <= 1'b0;
            near_reg         <= 1'b0;
            view_reg         <= 1'b0;
        end
        else if (advance)
        begin
            pending_x_reg    <= pending_x_next;
            pending_y_reg    <= pending_y_next;
            stick_x_reg      <= stick_x_next;
            stick_y_reg      <= stick_y_next;
            stick_r_reg      <= stick_r_next;
            lock_roll_reg    <= lock_roll_next;
            lock_drained_reg <= lock_drained_next;
            right_down_reg   <= right_down_next;
            press_time_reg   <= press_time_next;
            drain_time_reg   <= drain_time_next;
            drain_seen_reg   <= drain_seen_next;
            active_reg       <= active_next;
            left_state_reg   <= left_state_next;
            sample_valid_reg <= sample_valid_next;
            tap_reg          <= tap_next;
            near_reg         <= near_next;
            view_reg         <= view_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result. The axes are the held sticks rounded to the nearest step,
    // halves upward; since the sticks never exceed full scale the result
    // always lies within plus or minus 127.
    // ------------------------------------------------------------------
    function automatic logic signed [7:0] round_axis(input logic signed [SW-1:0] st);
        logic signed [SW:0] biased;
        biased     = (SW+1)'(st) + HALF_LSB;
        round_axis = 8'(biased >>> FRAC_BITS);
    endfunction

    assign out_valid      = out_valid_reg;
    assign sample_valid   = sample_valid_reg;
    assign axis_x         = round_axis(stick_x_reg);
    assign axis_y         = round_axis(stick_y_reg);
    assign axis_r         = round_axis(stick_r_reg);
    assign fire_button    = left_state_reg;
    assign roll_locked    = lock_roll_reg;
    assign tap_action     = tap_reg;
    assign nearest_action = near_reg;
    assign view_action    = view_reg;
    assign engaged        = active_reg;

endmodule

`default_nettype wire

FILE: bench/tb_mouse_to_virtual_stick.sv
// ----------------------------------------------------------------------------
// tb_mouse_to_virtual_stick
// Self-checking bench for the mouse to virtual stick block. Requests are
// queued by a stimulus process, driven with random gaps and checked on the
// result channel against a cycle-free model of the stick, the pending sums,
// roll lock, tap detection and the one-shot actions.
// ----------------------------------------------------------------------------

module tb_mouse_to_virtual_stick
    import mtvs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    // Settling margin for the block's input and result registers to run dry.
    localparam int SETTLE_CYCLES = 6;

    localparam int FRAC    = FRAC_BITS_DEFAULT;
    localparam int PEND_W  = PENDING_WIDTH_DEFAULT;
    localparam int STICK_W = FRAC + 8;

    localparam longint STICK_LIM = STICK_FULL_SCALE * (64'sd1 <<< FRAC);
    localparam longint PEND_LIM  = 64'sd1 <<< (PEND_W - 1);

    // Mode three has no meaning; the block must only report its state.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Number of full-scale frames sent back to back to drive the pending sums
    // into saturation before a single sample.
    localparam int FLOOD_FRAMES = 280;

    typedef struct packed {
        logic [1:0]  mode;
        logic        allowed;
        logic        captured;
        logic        chat_inactive;
        logic [15:0] rel_x;
        logic [15:0] rel_y;
        logic        left_held;
        logic        right_held;
        logic        middle_pressed;
        logic        x1_pressed;
        logic [31:0] now_us;
    } stick_req_t;

    typedef struct packed {
        logic       sample_valid;
        logic [7:0] axis_x;
        logic [7:0] axis_y;
        logic [7:0] axis_r;
        logic       fire_button;
        logic       roll_locked;
        logic       tap_action;
        logic       nearest_action;
        logic       view_action;
        logic       engaged;
    } stick_report_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                        cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data  = '0;

    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic [1:0]         mode           = MODE_FRAME;
    logic               allowed        = 1'b0;
    logic               captured       = 1'b0;
    logic               chat_inactive  = 1'b0;
    logic signed [15:0] rel_x          = '0;
    logic signed [15:0] rel_y          = '0;
    logic               left_held      = 1'b0;
    logic               right_held     = 1'b0;
    logic               middle_pressed = 1'b0;
    logic               x1_pressed     = 1'b0;
    logic [31:0]        now_us         = '0;

    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic               sample_valid;
    logic signed [7:0]  axis_x;
    logic signed [7:0]  axis_y;
    logic signed [7:0]  axis_r;
    logic               fire_button;
    logic               roll_locked;
    logic               tap_action;
    logic               nearest_action;
    logic               view_action;
    logic               engaged;

    always #(CLK_PERIOD / 2) clk = ~clk;

    mouse_to_virtual_stick dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .allowed        (allowed),
        .captured       (captured),
        .chat_inactive  (chat_inactive),
        .rel_x          (rel_x),
        .rel_y          (rel_y),
        .left_held      (left_held),
        .right_held     (right_held),
        .middle_pressed (middle_pressed),
        .x1_pressed     (x1_pressed),
        .now_us         (now_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_valid   (sample_valid),
        .axis_x         (axis_x),
        .axis_y         (axis_y),
        .axis_r         (axis_r),
        .fire_button    (fire_button),
        .roll_locked    (roll_locked),
        .tap_action     (tap_action),
        .nearest_action (nearest_action),
        .view_action    (view_action),
        .engaged        (engaged)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping: requests waiting to be driven, the reports predicted
    // for accepted requests, and the knobs that shape the traffic.
    // ------------------------------------------------------------------------
    stick_req_t    pending_reqs[$];
    stick_report_t stick_reports_q[$];
    stick_req_t    drive_req;
    stick_report_t next_report;

    int   send_idle_pct  = 0;
    int   stall_pct      = 0;
    logic hold_send      = 1'b0;
    int   mismatch_count = 0;

    // Stimulus generator state: the running timestamp and the buttons that
    // are held across frames.
    logic [31:0] gen_now;
    logic        gen_right;
    logic        gen_left;

    // ------------------------------------------------------------------------
    // Stick model. Its own copy of the configuration registers, written
    // alongside the block's, and of every piece of state that shows at the
    // result port.
    // ------------------------------------------------------------------------
    logic               cfg_enable_m;
    logic [3:0]         cfg_step_m;
    logic               cfg_invert_m;
    logic [19:0]        cfg_tap_m;
    logic [19:0]        cfg_gap_m;

    logic signed [PEND_W-1:0]  pend_x_m;
    logic signed [PEND_W-1:0]  pend_y_m;
    logic signed [STICK_W-1:0] stick_x_m;
    logic signed [STICK_W-1:0] stick_y_m;
    logic signed [STICK_W-1:0] stick_r_m;
    logic signed [7:0]         axis_m [3];
    logic                      roll_m;
    logic                      drained_m;
    logic                      right_down_m;
    logic [31:0]               press_time_m;
    logic [31:0]               drain_time_m;
    logic                      drain_seen_m;
    logic                      active_m;
    logic                      left_m;

    function automatic longint clamp_to(input longint v, input longint lim_lo,
                                        input longint lim_hi);
        return (v < lim_lo) ? lim_lo : ((v > lim_hi) ? lim_hi : v);
    endfunction

    function automatic logic signed [PEND_W-1:0] pend_sat(input longint v);
        return PEND_W'(clamp_to(v, -PEND_LIM, PEND_LIM - 1));
    endfunction

    function automatic logic signed [STICK_W-1:0] stick_sat(input longint v);
        return STICK_W'(clamp_to(v, -STICK_LIM, STICK_LIM));
    endfunction

    // Motion gain of 127/256 times two to the (step - 4), in stick fraction
    // units. A negative shift floors, which the arithmetic shift gives.
    function automatic longint gain(input longint pixels);
        int     step;
        int     sh;
        longint m;
        step = (cfg_step_m > SENS_STEP_MAX) ? int'(SENS_STEP_MAX) : int'(cfg_step_m);
        sh   = FRAC + step - SCALE_BIAS;
        m    = pixels * STICK_FULL_SCALE;
        return (sh >= 0) ? (m <<< sh) : (m >>> (-sh));
    endfunction

    // Rounds half up: floor(stick + 0.5).
    function automatic logic signed [7:0] to_axis(input longint st);
        longint t;
        t = (st + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        return t[7:0];
    endfunction

    function automatic void refresh_axes();
        axis_m[0] = to_axis(longint'(stick_x_m));
        axis_m[1] = to_axis(longint'(stick_y_m));
        axis_m[2] = to_axis(longint'(stick_r_m));
    endfunction

    // The press time survives this; a hard reset clears it separately.
    function automatic void clear_stick_model();
        pend_x_m     = '0;
        pend_y_m     = '0;
        stick_x_m    = '0;
        stick_y_m    = '0;
        stick_r_m    = '0;
        axis_m[0]    = '0;
        axis_m[1]    = '0;
        axis_m[2]    = '0;
        roll_m       = 1'b0;
        drained_m    = 1'b0;
        right_down_m = 1'b0;
        drain_time_m = '0;
        drain_seen_m = 1'b0;
        active_m     = 1'b0;
        left_m       = 1'b0;
    endfunction

    // Advances the model by one accepted request and queues the report that
    // the block must give for it.
    task automatic predict_stick_report(input stick_req_t r);
        stick_report_t e;
        logic [31:0]   held_us;
        logic [31:0]   gap_us;
        logic          tap_hit;
        logic          stale;
        longint        dx;
        longint        dy;
        e       = '0;
        tap_hit = 1'b0;
        case (r.mode)
            MODE_FRAME:
            begin
                if (!cfg_enable_m || !(r.allowed && r.captured))
                    clear_stick_model();
                else
                begin
                    active_m = 1'b1;
                    pend_x_m = pend_sat(longint'(pend_x_m) + longint'($signed(r.rel_x)));
                    pend_y_m = pend_sat(longint'(pend_y_m) + longint'($signed(r.rel_y)));
                    left_m   = r.left_held;
                    held_us  = r.now_us - press_time_m;
                    if (r.right_held && !right_down_m)
                        press_time_m = r.now_us;
                    else if (!r.right_held && right_down_m && held_us < {12'd0, cfg_tap_m})
                        tap_hit = 1'b1;
                    right_down_m = r.right_held;
                    // The hold time is taken again, as a fresh press restarts it.
                    held_us = r.now_us - press_time_m;
                    roll_m  = r.right_held && (held_us >= {12'd0, cfg_tap_m});
                    if (r.chat_inactive)
                    begin
                        e.tap_action     = tap_hit;
                        e.nearest_action = r.middle_pressed;
                        e.view_action    = r.x1_pressed;
                    end
                end
            end
            MODE_SAMPLE:
            begin
                if (!r.allowed || !cfg_enable_m)
                    clear_stick_model();
                else if (active_m)
                begin
                    gap_us       = r.now_us - drain_time_m;
                    stale        = !drain_seen_m || (gap_us > {12'd0, cfg_gap_m});
                    drain_time_m = r.now_us;
                    drain_seen_m = 1'b1;
                    if (stale)
                        refresh_axes();
                    else
                    begin
                        dx = gain(longint'(pend_x_m));
                        dy = gain(longint'(pend_y_m));
                        if (!cfg_invert_m)
                            dy = -dy;
                        // Entering or leaving roll lock restarts the roll stick.
                        if (roll_m != drained_m)
                        begin
                            drained_m = roll_m;
                            stick_r_m = '0;
                        end
                        if (roll_m)
                            stick_r_m = stick_sat(longint'(stick_r_m) + dx);
                        else
                        begin
                            stick_r_m = '0;
                            stick_x_m = stick_sat(longint'(stick_x_m) + dx);
                            stick_y_m = stick_sat(longint'(stick_y_m) + dy);
                        end
                        refresh_axes();
                    end
                    pend_x_m       = '0;
                    pend_y_m       = '0;
                    e.sample_valid = 1'b1;
                end
            end
            MODE_DISCARD:
            begin
                pend_x_m     = '0;
                pend_y_m     = '0;
                drain_time_m = r.now_us;
                drain_seen_m = 1'b1;
            end
            default:
            begin
            end
        endcase
        e.axis_x      = axis_m[0];
        e.axis_y      = axis_m[1];
        e.axis_r      = axis_m[2];
        e.fire_button = left_m;
        e.roll_locked = roll_m;
        e.engaged     = active_m;
        stick_reports_q.push_back(e);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. A request is predicted at the edge where it is accepted; the
    // next one is offered only once the current one has gone, so valid and
    // the payload never move while a request waits.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_stick_report(drive_req);
            if (!in_valid || in_ready)
            begin
                if (!hold_send && pending_reqs.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    drive_req      = pending_reqs.pop_front();
                    in_valid       <= 1'b1;
                    mode           <= drive_req.mode;
                    allowed        <= drive_req.allowed;
                    captured       <= drive_req.captured;
                    chat_inactive  <= drive_req.chat_inactive;
                    rel_x          <= drive_req.rel_x;
                    rel_y          <= drive_req.rel_y;
                    left_held      <= drive_req.left_held;
                    right_held     <= drive_req.right_held;
                    middle_pressed <= drive_req.middle_pressed;
                    x1_pressed     <= drive_req.x1_pressed;
                    now_us         <= drive_req.now_us;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each result taken is matched against the oldest prediction;
    // ready is redrawn every cycle so stalls land on any stage of the work.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (stick_reports_q.size() == 0)
                begin
                    $error("result taken with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    next_report = stick_reports_q.pop_front();
                    check_field("sample_valid", 32'(next_report.sample_valid),
                                32'(sample_valid));
                    check_field("axis_x", 32'($signed(next_report.axis_x)), 32'(axis_x));
                    check_field("axis_y", 32'($signed(next_report.axis_y)), 32'(axis_y));
                    check_field("axis_r", 32'($signed(next_report.axis_r)), 32'(axis_r));
                    check_field("fire_button", 32'(next_report.fire_button),
                                32'(fire_button));
                    check_field("roll_locked", 32'(next_report.roll_locked),
                                32'(roll_locked));
                    check_field("tap_action", 32'(next_report.tap_action),
                                32'(tap_action));
                    check_field("nearest_action", 32'(next_report.nearest_action),
                                32'(nearest_action));
                    check_field("view_action", 32'(next_report.view_action),
                                32'(view_action));
                    check_field("engaged", 32'(next_report.engaged), 32'(engaged));
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Queues one request, moving the timestamp on by the given interval first.
    task automatic push_req(input logic [1:0] m, input logic al, input logic cap,
                            input logic chat, input logic [15:0] rx,
                            input logic [15:0] ry, input logic lh, input logic rh,
                            input logic mp, input logic xp, input int unsigned dt);
        stick_req_t q;
        gen_now          = gen_now + dt;
        q.mode           = m;
        q.allowed        = al;
        q.captured       = cap;
        q.chat_inactive  = chat;
        q.rel_x          = rx;
        q.rel_y          = ry;
        q.left_held      = lh;
        q.right_held     = rh;
        q.middle_pressed = mp;
        q.x1_pressed     = xp;
        q.now_us         = gen_now;
        pending_reqs.push_back(q);
    endtask

    // Mostly gentle hand motion, with some arbitrary and full-scale values.
    function automatic logic [15:0] pick_motion();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80)
            return 16'($urandom_range(120) - 60);
        else if (r < 93)
            return 16'($urandom());
        else if (r < 96)
            return 16'h8000;
        else
            return 16'h7fff;
    endfunction

    // Play-like traffic: mostly frames and samples with the pointer captured,
    // buttons held over several frames so that holds cross the tap window,
    // and now and then a long pause or a jump that wraps the timestamp.
    task automatic queue_play(input int n);
        int unsigned pick;
        int unsigned dt;
        logic [1:0]  m;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 58)
                m = MODE_FRAME;
            else if (pick < 88)
                m = MODE_SAMPLE;
            else if (pick < 97)
                m = MODE_DISCARD;
            else
                m = MODE_UNUSED;
            if ($urandom_range(99) < 15)
                gen_right = ~gen_right;
            if ($urandom_range(99) < 20)
                gen_left = ~gen_left;
            pick = $urandom_range(99);
            if (pick < 90)
                dt = $urandom_range(9000);
            else if (pick < 97)
                dt = $urandom_range(400000, 20000);
            else
                dt = $urandom();
            push_req(m, $urandom_range(99) >= 4, $urandom_range(99) >= 4,
                     $urandom_range(99) >= 15, pick_motion(), pick_motion(),
                     gen_left, gen_right, $urandom_range(99) < 10,
                     $urandom_range(99) < 10, dt);
        end
    endtask

    // Waits until nothing is queued, offered or expected, then lets the
    // block's pipeline run dry.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || stick_reports_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_WIDTH-1:0];
        case (idx)
            REG_ENABLE:     cfg_enable_m = val[0];
            REG_SENS_STEP:  cfg_step_m   = val[3:0];
            REG_INVERT_Y:   cfg_invert_m = val[0];
            REG_TAP_WINDOW: cfg_tap_m    = val[19:0];
            REG_MAX_GAP:    cfg_gap_m    = val[19:0];
            default:
            begin
            end
        endcase
    endtask

    // Writes all five registers back to back; only called with the block idle.
    task automatic configure(input int unsigned en, input int unsigned step,
                             input int unsigned inv, input int unsigned tap,
                             input int unsigned gap);
        write_reg(REG_ENABLE, en);
        write_reg(REG_SENS_STEP, step);
        write_reg(REG_INVERT_Y, inv);
        write_reg(REG_TAP_WINDOW, tap);
        write_reg(REG_MAX_GAP, gap);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // One phase of random traffic under one register setting and one
    // pattern of idling. A flood phase first saturates the pending sums; a
    // pause phase stops the sender halfway until every result is back.
    task automatic run_phase(input int unsigned en, input int unsigned step,
                             input int unsigned inv, input int unsigned tap,
                             input int unsigned gap, input int s_idle,
                             input int r_stall, input int n, input bit flood,
                             input bit pause);
        configure(en, step, inv, tap, gap);
        send_idle_pct = s_idle;
        stall_pct     = r_stall;
        if (flood)
        begin
            // A sample opens the interval so the one after the burst counts.
            push_req(MODE_SAMPLE, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0,
                     1'b0, 2000);
            repeat (FLOOD_FRAMES)
                push_req(MODE_FRAME, 1'b1, 1'b1, 1'b0, 16'h7fff, 16'h8000, 1'b1,
                         1'b0, 1'b0, 1'b0, 10);
            push_req(MODE_SAMPLE, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0,
                     1'b0, 10);
        end
        queue_play(n);
        if (pause)
        begin
            do
                @(negedge clk);
            while (pending_reqs.size() > n / 2);
            hold_send = 1'b1;
            do
                @(negedge clk);
            while (in_valid || stick_reports_q.size() != 0);
            repeat ($urandom_range(12, 2)) @(negedge clk);
            hold_send = 1'b0;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        // The model starts from the block's reset state.
        cfg_enable_m = 1'b0;
        cfg_step_m   = SENS_STEP_RESET;
        cfg_invert_m = 1'b0;
        cfg_tap_m    = TAP_WINDOW_RESET;
        cfg_gap_m    = MAX_GAP_RESET;
        press_time_m = '0;
        clear_stick_model();

        gen_now   = $urandom();
        gen_right = 1'b0;
        gen_left  = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Straight out of reset the block is disabled: a frame and a sample
        // must both clear state, and discard and the unused mode leave the report as it was.
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, 16'd5, 16'd5, 1'b1, 1'b1, 1'b1,
                 1'b1, 100);
        push_req(MODE_SAMPLE, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 100);
        push_req(MODE_DISCARD, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 100);
        push_req(MODE_UNUSED, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 100);
        wait_idle();

        // Directed requests with a short tap window and the widest gap.
        configure(1, 4, 0, 20000, 1048575);
        // Frames with the flight not allowed, then with the pointer released.
        push_req(MODE_FRAME, 1'b0, 1'b1, 1'b1, 16'd9, 16'd9, 1'b1, 1'b0, 1'b0,
                 1'b0, 100);
        push_req(MODE_FRAME, 1'b1, 1'b0, 1'b1, 16'd9, 16'd9, 1'b1, 1'b0, 1'b0,
                 1'b0, 100);
        // A sample before any frame has made the block active changes nothing.
        push_req(MODE_SAMPLE, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 100);
        // Extreme motion with both actions, then the opposite extremes with chat open.
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, 16'h7fff, 16'h8000, 1'b1, 1'b0, 1'b1,
                 1'b1, 100);
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b0, 16'h8000, 16'h7fff, 1'b0, 1'b0, 1'b1,
                 1'b1, 100);
        // First sample: no drain yet, so the motion is thrown away.
        push_req(MODE_SAMPLE, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1000);
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, 16'd40, -16'sd25, 1'b0, 1'b0, 1'b0,
                 1'b0, 1000);
        push_req(MODE_SAMPLE, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 5000);
        // A quick right click gives a tap; with chat open it is held back.
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0, 1000);
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 500);
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0, 1000);
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 500);
        // A long hold engages roll lock; motion then goes to the roll stick.
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0, 1000);
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, 16'd30, '0, 1'b0, 1'b1, 1'b0, 1'b0,
                 25000);
        push_req(MODE_SAMPLE, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 500);
        // Release ends the lock and the next sample returns to pitch and yaw.
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, 16'd10, 16'd10, 1'b0, 1'b0, 1'b0,
                 1'b0, 500);
        push_req(MODE_SAMPLE, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 500);
        // A sample with the flight not allowed clears everything.
        push_req(MODE_SAMPLE, 1'b0, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 500);
        push_req(MODE_FRAME, 1'b1, 1'b1, 1'b1, 16'd3, 16'd3, 1'b1, 1'b0, 1'b0,
                 1'b0, 500);
        push_req(MODE_DISCARD, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 500);
        push_req(MODE_UNUSED, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 500);
        wait_idle();

        // Random phases. Between them the settings cover gain steps 0, 2 to 6 and 8 (with
        // one above the top step), both Y senses, a zero tap window that
        // locks at once, and the smallest and largest gap and window.
        run_phase(1, 4, 0, 250000, 100000, 0, 0, 230, 1'b1, 1'b0);
        run_phase(1, 0, 1, 30000, 40000, 68, 0, 230, 1'b0, 1'b1);
        run_phase(1, 8, 0, 1, 1048575, 0, 68, 230, 1'b0, 1'b0);
        run_phase(1, 15, 1, 0, 1, 31, 31, 230, 1'b0, 1'b0);
        run_phase(0, 5, 0, 20000, 20000, 0, 0, 40, 1'b0, 1'b0);
        run_phase(1, 6, 0, 1048575, 20000, 31, 31, 230, 1'b0, 1'b0);
        run_phase(1, 2, 1, 50000, 60000, 68, 0, 230, 1'b0, 1'b0);
        run_phase(1, 3, 0, 12000, 30000, 0, 68, 100, 1'b0, 1'b0);

        // A few more cycles to catch any stray result.
        repeat (4 * SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
